### sv/assert_macros.svh
// Assertion macros shared by the RTL files.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

### sv/dpcw_pkg.sv
// Shared types, constants and the microcode table of the deadband PI unit.
// No dependencies.
package dpcw_pkg;

  localparam int unsigned RING_DEPTH_DEF = 128;
  localparam int unsigned DATA_W         = 16;
  localparam int unsigned FRAC_W         = 4;
  localparam int unsigned WIN_W          = 10;
  localparam int unsigned CFG_IDX_W      = 3;

  typedef logic signed [DATA_W-1:0] word_t;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FRAC_BITS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CEILING    = 3'd5;

  // Reset values of the registers
  localparam logic [FRAC_W-1:0] FRAC_BITS_RST  = 4'd10;
  localparam word_t             PROP_GAIN_RST  = 16'sd1024;
  localparam word_t             INTEG_GAIN_RST = 16'sd128;
  localparam logic [WIN_W-1:0]  WINDOW_LEN_RST = 10'd80;
  localparam word_t             FLOOR_RST      = -16'sd16384;
  localparam word_t             CEILING_RST    = 16'sd16384;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_WALK,
    ST_MULI,
    ST_MULP,
    ST_SUM
  } step_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_NOT_LAST,
    C_NO_FIRE,
    C_WIN_ZERO,
    C_WALK_MORE,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    logic  in_ready;
    logic  clr_we;
    logic  load_item;
    logic  idx_dec;
    logic  latch_cur;
    logic  walk;
    logic  mul_en;
    logic  mul_prop;
    logic  term_en;
    logic  out_load;
    cond_e cond;
    step_e to_t;
    step_e to_f;
  } ctrl_t;

  // Microcode ROM: one control word per step
  function automatic ctrl_t ucode(input step_e st);
    ctrl_t w;
    w = '0;
    w.cond = C_NEVER;
    w.to_t = ST_IDLE;
    w.to_f = ST_IDLE;
    unique case (st)
      ST_CLEAR: begin
        w.clr_we = 1'b1;
        w.cond   = C_NOT_LAST;
        w.to_t   = ST_CLEAR;
        w.to_f   = ST_IDLE;
      end
      ST_IDLE: begin
        w.in_ready  = 1'b1;
        w.load_item = 1'b1;
        w.cond      = C_NO_FIRE;
        w.to_t      = ST_IDLE;
        w.to_f      = ST_RD0;
      end
      ST_RD0: begin
        w.idx_dec = 1'b1;
        w.cond    = C_WIN_ZERO;
        w.to_t    = ST_MULI;
        w.to_f    = ST_RD1;
      end
      ST_RD1: begin
        w.idx_dec   = 1'b1;
        w.latch_cur = 1'b1;
        w.to_f      = ST_WALK;
      end
      ST_WALK: begin
        w.idx_dec   = 1'b1;
        w.latch_cur = 1'b1;
        w.walk      = 1'b1;
        w.cond      = C_WALK_MORE;
        w.to_t      = ST_WALK;
        w.to_f      = ST_MULI;
      end
      ST_MULI: begin
        w.mul_en = 1'b1;
        w.to_f   = ST_MULP;
      end
      ST_MULP: begin
        w.mul_en   = 1'b1;
        w.mul_prop = 1'b1;
        w.term_en  = 1'b1;
        w.to_f     = ST_SUM;
      end
      ST_SUM: begin
        w.out_load = 1'b1;
        w.cond     = C_OUT_BUSY;
        w.to_t     = ST_SUM;
        w.to_f     = ST_IDLE;
      end
      default: begin
        w.to_f = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

### sv/dpcw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dpcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/deadband_pi_controller_windowed_unit.sv
// Deadband PI controller with a windowed integral over an error ring.
// Depends on dpcw_pkg, dpcw_ram and assert_macros.svh.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid_i/in_ready_o, band_low/high, me | sink
//  out     | out_valid_o/out_ready_i, drive_o         | source
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i          | write only
//
// A result is loaded in SUM after the accepting edge; the steps between are RD0, RD1,
// the walk, MULI and MULP (the walk ends early when the sum hits a clamp; a zero
// window skips RD1 and the walk). The walk reads one ring entry per cycle through the
// single read port of the ring RAM. The next word is taken only back in IDLE.
// After reset the ring is swept to zero, entry by entry, with in_ready_o low.
// A result waits in the output register; the next word is taken meanwhile and
// the sequencer holds in its final step only if the previous result is unread.
module deadband_pi_controller_windowed_unit
  #(
    parameter int unsigned RING_DEPTH = dpcw_pkg::RING_DEPTH_DEF
  ) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [dpcw_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [dpcw_pkg::DATA_W-1:0]           cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [dpcw_pkg::DATA_W-1:0]    band_low_i,
  input  logic signed [dpcw_pkg::DATA_W-1:0]    band_high_i,
  input  logic signed [dpcw_pkg::DATA_W-1:0]    measured_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [dpcw_pkg::DATA_W-1:0]    drive_o
);

  import dpcw_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [AW-1:0] IDX_LAST = AW'(RING_DEPTH - 1);

  function automatic logic [AW-1:0] ring_adv(input logic [AW-1:0] i);
    return (i == IDX_LAST) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] i);
    return (i == '0) ? IDX_LAST : i - AW'(1);
  endfunction

  // Configuration registers
  logic [FRAC_W-1:0] frac_q;
  word_t             kp_q, ki_q, floor_q, ceil_q;
  logic [WIN_W-1:0]  win_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q  <= FRAC_BITS_RST;
      kp_q    <= PROP_GAIN_RST;
      ki_q    <= INTEG_GAIN_RST;
      win_q   <= WINDOW_LEN_RST;
      floor_q <= FLOOR_RST;
      ceil_q  <= CEILING_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAC_BITS:  frac_q  <= cfg_data_i[FRAC_W-1:0];
        CFG_PROP_GAIN:  kp_q    <= cfg_data_i;
        CFG_INTEG_GAIN: ki_q    <= cfg_data_i;
        CFG_WINDOW_LEN: win_q   <= cfg_data_i[WIN_W-1:0];
        CFG_FLOOR:      floor_q <= cfg_data_i;
        CFG_CEILING:    ceil_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer
  step_e upc_q, upc_d;
  ctrl_t ctrl;
  logic  cond_hit;

  logic  in_fire, out_busy, walk_more, walk_hi, walk_lo;
  logic [AW-1:0]    idx_q, idx_d, ptr_q, ptr_d;
  logic [WIN_W-1:0] n_q, n_d;

  always_comb begin
    ctrl = ucode(upc_q);
  end

  always_comb begin
    case (ctrl.cond)
      C_NOT_LAST:  cond_hit = (idx_q != IDX_LAST);
      C_NO_FIRE:   cond_hit = !in_valid_i;
      C_WIN_ZERO:  cond_hit = (n_q == '0);
      C_WALK_MORE: cond_hit = walk_more;
      C_OUT_BUSY:  cond_hit = out_busy;
      default:     cond_hit = 1'b0;
    endcase
    upc_d = cond_hit ? ctrl.to_t : ctrl.to_f;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= ST_CLEAR;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign in_ready_o = ctrl.in_ready;
  assign in_fire    = in_valid_i & ctrl.in_ready;

  // Deadband error
  word_t err_d;
  always_comb begin
    if (measured_i < band_low_i) begin
      err_d = band_low_i - measured_i;
    end else if (measured_i > band_high_i) begin
      err_d = band_high_i - measured_i;
    end else begin
      err_d = '0;
    end
  end

  // Ring RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  word_t         ram_wdata;
  word_t         ram_rdata;

  assign ram_we    = ctrl.clr_we | in_fire;
  assign ram_waddr = ctrl.clr_we ? idx_q : ptr_q;
  assign ram_wdata = ctrl.clr_we ? '0 : err_d;

  dpcw_ram #(
    .WIDTH (DATA_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // Walk datapath
  word_t acc_q, acc_d, cur_q, integ_q, err_q;

  assign acc_d     = acc_q + cur_q - ram_rdata;
  assign walk_hi   = acc_d > ceil_q;
  assign walk_lo   = acc_d < floor_q;
  assign walk_more = !walk_hi && !walk_lo && (n_q != WIN_W'(1));

  always_comb begin
    idx_d = idx_q;
    ptr_d = ptr_q;
    n_d   = n_q;
    if (ctrl.clr_we) begin
      idx_d = ring_adv(idx_q);
    end else if (in_fire) begin
      ptr_d = ring_adv(ptr_q);
      idx_d = ring_adv(ptr_q);
      n_d   = win_q;
    end else if (ctrl.idx_dec) begin
      idx_d = ring_back(idx_q);
    end
    if (ctrl.walk) begin
      n_d = n_q - WIN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      ptr_q <= '0;
      n_q   <= '0;
    end else begin
      idx_q <= idx_d;
      ptr_q <= ptr_d;
      n_q   <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      err_q   <= err_d;
      acc_q   <= '0;
      integ_q <= '0;
    end
    if (ctrl.latch_cur) begin
      cur_q <= ram_rdata;
    end
    if (ctrl.walk) begin
      acc_q <= acc_d;
      // ceiling is tested first
      if (walk_hi) begin
        integ_q <= ceil_q;
      end else if (walk_lo) begin
        integ_q <= floor_q;
      end else begin
        integ_q <= acc_d;
      end
    end
  end

  // Shared multiplier: integral term first, then proportional term
  logic signed [2*DATA_W-1:0] prod_q, prod_sh;
  word_t mul_a, mul_b, term_q, drive_d;

  assign mul_a   = ctrl.mul_prop ? kp_q : ki_q;
  assign mul_b   = ctrl.mul_prop ? err_q : integ_q;
  assign prod_sh = prod_q >>> frac_q;
  assign drive_d = (err_q == '0) ? '0 : term_q + prod_sh[DATA_W-1:0];

  always_ff @(posedge clk_i) begin
    if (ctrl.mul_en) begin
      prod_q <= (2*DATA_W)'(mul_a) * (2*DATA_W)'(mul_b);
    end
    if (ctrl.term_en) begin
      term_q <= prod_sh[DATA_W-1:0];
    end
  end

  // Output register
  logic  out_valid_q, out_load;
  word_t drive_q;

  assign out_busy = out_valid_q && !out_ready_i;
  assign out_load = ctrl.out_load && !out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      drive_q <= drive_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

  `ASSERT_CLK(a_ram_we_src, ram_we |-> (upc_q == ST_CLEAR || in_fire),
              "ring written outside clear sweep or accept")
  `ASSERT_CLK(a_out_from_sum, $rose(out_valid_q) |-> $past(upc_q == ST_SUM),
              "result raised outside final step")
  `ASSERT_NEVER(a_walk_count, upc_q == ST_WALK && n_q == '0,
                "walk entered with empty window count")
  `ASSERT_CLK(a_ptr_adv, in_fire |=> ptr_q != $past(ptr_q),
              "write pointer did not advance on accept")

endmodule

### sim/deadband_pi_controller_windowed_unit_tb.sv
// Self-checking bench for the deadband PI unit with a windowed integral.
// Uses dpcw_pkg and the RTL top; a scoreboard class tracks ring, pointer and
// registers and predicts every drive word.
module deadband_pi_controller_windowed_unit_tb;
  import dpcw_pkg::*;

  localparam int unsigned RING   = RING_DEPTH_DEF;
  localparam int unsigned PTR_W  = $clog2(RING_DEPTH_DEF);
  localparam int          STALL_LIMIT = 6000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          ITEM_TARGET = 1650;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_FRAC_BITS;
  logic [DATA_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  word_t                band_low = '0;
  word_t                band_high = '0;
  word_t                measured = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  word_t                drive;

  bit calm = 1'b0;
  bit hold_req = 1'b0;

  deadband_pi_controller_windowed_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .band_low_i  (band_low),
    .band_high_i (band_high),
    .measured_i  (measured),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .drive_o     (drive)
  );

  class drive_scoreboard;
    logic [FRAC_W-1:0] frac;
    word_t             kp;
    word_t             ki;
    logic [WIN_W-1:0]  win;
    word_t             floor_v;
    word_t             ceil_v;
    word_t             ring [RING];
    logic [PTR_W-1:0]  wptr;
    word_t             drive_q [$];
    int                errors;

    function new();
      frac    = FRAC_BITS_RST;
      kp      = PROP_GAIN_RST;
      ki      = INTEG_GAIN_RST;
      win     = WINDOW_LEN_RST;
      floor_v = FLOOR_RST;
      ceil_v  = CEILING_RST;
      foreach (ring[i]) ring[i] = '0;
      wptr    = '0;
      errors  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] v);
      case (idx)
        CFG_FRAC_BITS:  frac    = v[FRAC_W-1:0];
        CFG_PROP_GAIN:  kp      = v;
        CFG_INTEG_GAIN: ki      = v;
        CFG_WINDOW_LEN: win     = v[WIN_W-1:0];
        CFG_FLOOR:      floor_v = v;
        CFG_CEILING:    ceil_v  = v;
        default: ;
      endcase
    endfunction

    // Full 32 bit product, floor shift, keep the low 16 bits.
    function word_t scaled(word_t a, word_t b);
      logic signed [31:0] p;
      logic signed [31:0] sh;
      p  = 32'(a) * 32'(b);
      sh = p >>> frac;
      return sh[DATA_W-1:0];
    endfunction

    // Walk back from the write pointer; stop at the first clamp hit.
    function word_t window_sum();
      logic [PTR_W-1:0] idx;
      logic [PTR_W-1:0] pidx;
      word_t            acc;
      int               n;
      idx = wptr;
      acc = '0;
      for (n = 0; n < int'(win); n++) begin
        pidx = idx - 1'b1;
        acc  = acc + ring[idx] - ring[pidx];
        if (acc > ceil_v) return ceil_v;
        if (acc < floor_v) return floor_v;
        idx = pidx;
      end
      return acc;
    endfunction

    function void note_input(word_t lo, word_t hi, word_t me);
      word_t err;
      word_t drv;
      if (lo <= me && me <= hi) err = '0;
      else if (me < lo) err = lo - me;
      else err = hi - me;
      ring[wptr] = err;
      wptr = wptr + 1'b1;
      drv = scaled(ki, window_sum()) + scaled(kp, err);
      if (err == '0) drv = '0;
      drive_q.push_back(drv);
    endfunction

    function void check_drive(word_t got);
      word_t want;
      if (drive_q.size() == 0) begin
        $display("%0t: unexpected drive word, expected none, actual %0d", $time, got);
        errors++;
      end else begin
        want = drive_q.pop_front();
        if (got !== want) begin
          $display("%0t: drive mismatch, expected %0d, actual %0d", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return drive_q.size();
    endfunction
  endclass

  drive_scoreboard sb = new();

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Receiver: random backpressure, long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid && out_ready) sb.check_drive(drive);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 20);
      end
    end
  end

  // Watchdog: count cycles with no word moving on either channel.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    sb.set_reg(idx, v);
    @(posedge clk_i);
  endtask

  task automatic write_all(input logic [FRAC_W-1:0] fb, input word_t kp, input word_t ki,
                           input logic [WIN_W-1:0] wl, input word_t fl, input word_t cl);
    write_reg(CFG_FRAC_BITS, DATA_W'(fb));
    write_reg(CFG_PROP_GAIN, kp);
    write_reg(CFG_INTEG_GAIN, ki);
    write_reg(CFG_WINDOW_LEN, DATA_W'(wl));
    write_reg(CFG_FLOOR, fl);
    write_reg(CFG_CEILING, cl);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold valid and payload until accepted, then maybe idle a few cycles.
  task automatic send_word(input word_t lo, input word_t hi, input word_t me);
    in_valid  <= 1'b1;
    band_low  <= lo;
    band_high <= hi;
    measured  <= me;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sb.note_input(lo, hi, me);
    if (!calm && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic word_t pick_gain();
    case ($urandom_range(7))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return word_t'($urandom_range(0, 2048)) - 16'sd1024;
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic gen_item(output word_t lo, output word_t hi, output word_t me);
    int mode;
    mode = $urandom_range(9);
    if (mode < 6) begin
      // band near a random center; measurement inside, below or above
      lo = word_t'($urandom) - word_t'($urandom_range(0, 300));
      hi = lo + word_t'($urandom_range(0, 600));
      case ($urandom_range(2))
        0: me = lo - word_t'($urandom_range(1, 400));
        1: me = lo + word_t'($urandom_range(0, 300));
        default: me = hi + word_t'($urandom_range(1, 400));
      endcase
    end else if (mode == 6) begin
      lo = word_t'($urandom);
      hi = word_t'($urandom);
      if (lo < hi) begin
        lo = lo ^ hi;
        hi = lo ^ hi;
        lo = lo ^ hi;
      end
      me = word_t'($urandom);
    end else begin
      lo = word_t'($urandom);
      hi = word_t'($urandom);
      me = word_t'($urandom);
    end
  endtask

  initial begin
    int                total;
    int                phase;
    int                n_items;
    int                r;
    int                c;
    logic [WIN_W-1:0]  wl;
    word_t             fl;
    word_t             cl;
    word_t             lo;
    word_t             hi;
    word_t             me;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: band edges, extremes, inverted bands.
    send_word(-16'sd32768, 16'sd32767, 16'sd0);
    send_word(16'sd0, 16'sd0, -16'sd32768);
    send_word(16'sd0, 16'sd0, 16'sd32767);
    send_word(16'sd32767, 16'sd32767, -16'sd32768);
    send_word(-16'sd32768, -16'sd32768, 16'sd32767);
    send_word(16'sd5, 16'sd10, 16'sd5);
    send_word(16'sd5, 16'sd10, 16'sd10);
    send_word(16'sd100, -16'sd100, 16'sd0);
    send_word(16'sd100, -16'sd100, 16'sd150);
    send_word(16'sd100, -16'sd100, -16'sd150);
    send_word(-16'sd200, 16'sd200, 16'sd4000);
    send_word(-16'sd200, 16'sd200, 16'sd0);
    drain();

    // Zero shift, extreme gains, window beyond the ring, widest clamps.
    write_all(4'd0, -16'sd32768, 16'sd32767, 10'd1023, -16'sd32768, 16'sd32767);
    send_word(16'sd0, 16'sd0, -16'sd7);
    send_word(16'sd0, 16'sd0, 16'sd9);
    send_word(16'sd0, 16'sd0, 16'sd0);
    send_word(-16'sd32768, -16'sd32768, 16'sd32767);
    send_word(16'sd1, 16'sd1, -16'sd1);
    send_word(16'sd32767, 16'sd32767, -16'sd32768);
    drain();

    // Widest shift, zero window, floor above ceiling.
    write_all(4'd15, 16'sd32767, -16'sd32768, 10'd0, 16'sd100, -16'sd100);
    send_word(16'sd0, 16'sd0, -16'sd32768);
    send_word(16'sd0, 16'sd0, 16'sd32767);
    send_word(16'sd10, 16'sd20, 16'sd15);
    drain();
    write_reg(CFG_WINDOW_LEN, DATA_W'(10'd3));
    cfg_we <= 1'b0;
    @(posedge clk_i);
    send_word(16'sd0, 16'sd0, -16'sd50);
    send_word(16'sd0, 16'sd0, 16'sd50);
    send_word(16'sd0, 16'sd0, 16'sd0);
    total = 24;

    phase = 0;
    while (total < ITEM_TARGET) begin
      drain();
      calm = 1'b0;
      r = $urandom_range(99);
      if (phase == 2) wl = 10'd3;
      else if (r < 70) wl = WIN_W'($urandom_range(0, 40));
      else if (r < 90) wl = WIN_W'($urandom_range(41, 200));
      else wl = WIN_W'($urandom_range(201, 1023));
      if ($urandom_range(4) == 0) begin
        fl = word_t'($urandom);
        cl = word_t'($urandom);
      end else begin
        c  = $urandom_range(0, 4000);
        fl = -word_t'(c);
        cl = word_t'($urandom_range(0, 4000));
      end
      write_all(FRAC_W'($urandom_range(0, 15)), pick_gain(), pick_gain(), wl, fl, cl);
      // fill the unit while the receiver holds off
      if (phase == 2) hold_req = 1'b1;
      calm = (phase == 5);
      n_items = (wl > 10'd200) ? 25 : 100;
      for (int i = 0; i < n_items; i++) begin
        gen_item(lo, hi, me);
        send_word(lo, hi, me);
        total++;
      end
      phase++;
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
